@@ design/swpi_pkg.sv @@
// ----------------------------------------------------------------------------
// swpi_pkg
// Shared constants and types for the stack with positional insert.
// ----------------------------------------------------------------------------
package swpi_pkg;

  // store depth and derived widths
  localparam int DEPTH     = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_OUT_W = 5;
  localparam int POS_W     = 8;
  localparam int WORD_W    = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // request codes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

endpackage

@@ design/stack_with_positional_insert_unit.sv @@
// ----------------------------------------------------------------------------
// stack_with_positional_insert_unit
// Bounded LIFO of signed words with push, pop and insert at a position.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: mode, position, value, taken on a rising edge with start
//   high and busy low. busy is only raised during reset, so a transaction can
//   be issued every cycle.
//   Result channel: status, popped_value and entry_count stand for exactly one
//   cycle with done high. The receiver cannot stall; results must be taken.
// Timing:
//   A request passes through the request register, then one pass through the
//   store update logic into the result register. Throughput is one
//   transaction per cycle; each request sees the store as left by the one
//   before it, since the store is updated in the same edge as its result.
// Store:
//   DEPTH word registers. An insert shifts every entry from the target slot
//   up to the top by one place in parallel; a push is an insert at the top.
// Reset:
//   Synchronous, active high. Clears the count, the request and result
//   strobes. Entry contents are left alone; only entries below the count
//   are ever read.
// ----------------------------------------------------------------------------
module stack_with_positional_insert_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode,
  input  logic [swpi_pkg::POS_W-1:0]       position,
  input  swpi_pkg::word_t                  value,
  output logic                             done,
  output logic [1:0]                       status,
  output swpi_pkg::word_t                  popped_value,
  output logic [swpi_pkg::CNT_OUT_W-1:0]   entry_count
);

  // request register
  logic                        req_valid;
  logic [1:0]                  req_mode;
  logic [swpi_pkg::POS_W-1:0]  req_pos;
  swpi_pkg::word_t             req_word;

  // stack state
  swpi_pkg::word_t             entries [swpi_pkg::DEPTH];
  swpi_pkg::cnt_t              count;

  // next-state and write controls
  swpi_pkg::cnt_t              count_next;
  swpi_pkg::cnt_t              top_cnt;
  swpi_pkg::cnt_t              slot_cnt;
  swpi_pkg::idx_t              slot;
  logic                        do_ins;
  logic                        is_full;
  logic                        pos_bad;
  logic [swpi_pkg::POS_W:0]    pos_ext;
  logic [swpi_pkg::POS_W:0]    lim_ext;
  logic [1:0]                  status_next;
  swpi_pkg::word_t             popped_next;
  logic [swpi_pkg::DEPTH-1:0]  wr_en;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    req_mode <= mode;
    req_pos  <= position;
    req_word <= value;
  end

  // single pass: classify the request, work out the new count and slot
  always_comb begin
    is_full     = (count == swpi_pkg::cnt_t'(swpi_pkg::DEPTH));
    top_cnt     = count - swpi_pkg::cnt_t'(1);
    pos_ext     = {1'b0, req_pos};
    lim_ext     = (swpi_pkg::POS_W + 1)'(count) + (swpi_pkg::POS_W + 1)'(1);
    pos_bad     = (req_pos == '0) || (pos_ext > lim_ext);
    slot_cnt    = count;
    do_ins      = 1'b0;
    status_next = swpi_pkg::ST_OK;
    popped_next = '0;
    count_next  = count;
    case (req_mode)
      swpi_pkg::MODE_PUSH: begin
        if (is_full) begin
          status_next = swpi_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + swpi_pkg::cnt_t'(1);
        end
      end
      swpi_pkg::MODE_POP: begin
        if (count == '0) begin
          status_next = swpi_pkg::ST_EMPTY;
          popped_next = '1;
        end else begin
          popped_next = entries[top_cnt[swpi_pkg::IDX_W-1:0]];
          count_next  = top_cnt;
        end
      end
      swpi_pkg::MODE_INSERT: begin
        if (pos_bad) begin
          status_next = swpi_pkg::ST_BADPOS;
        end else if (is_full) begin
          status_next = swpi_pkg::ST_FULL;
        end else begin
          // new word lands at index count+1-position
          slot_cnt   = count + swpi_pkg::cnt_t'(1) - swpi_pkg::cnt_t'(req_pos);
          do_ins     = 1'b1;
          count_next = count + swpi_pkg::cnt_t'(1);
        end
      end
      default: begin
        status_next = swpi_pkg::ST_OK;
      end
    endcase
    slot = slot_cnt[swpi_pkg::IDX_W-1:0];
  end

  // entries from the slot up to the new top take part in the shift
  always_comb begin
    for (int i = 0; i < swpi_pkg::DEPTH; i++) begin
      wr_en[i] = req_valid && do_ins
                 && (swpi_pkg::cnt_t'(i) >= slot_cnt)
                 && (swpi_pkg::cnt_t'(i) <= count);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < swpi_pkg::DEPTH; i++) begin
      if (wr_en[i]) begin
        if (swpi_pkg::idx_t'(i) == slot || i == 0) begin
          entries[i] <= req_word;
        end else begin
          entries[i] <= entries[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        count <= count_next;
      end
    end
    status       <= status_next;
    popped_value <= popped_next;
    entry_count  <= swpi_pkg::CNT_OUT_W'(count_next);
  end

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= swpi_pkg::cnt_t'(swpi_pkg::DEPTH))
    else $error("stack count beyond depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !req_valid |=> !done)
    else $error("result without a request");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    req_valid && status_next == swpi_pkg::ST_FULL
      |-> count == swpi_pkg::cnt_t'(swpi_pkg::DEPTH))
    else $error("full reported below depth");

  a_ok_insert_grows: assert property (@(posedge clk) disable iff (rst)
    req_valid && do_ins |=> count == $past(count) + swpi_pkg::cnt_t'(1))
    else $error("insert did not grow the stack");

endmodule

@@ tb/sv/stack_result_check.sv @@
// ----------------------------------------------------------------------------
// stack_result_check
// Watches the request and result channels of the stack, predicts each reply
// from a shadow copy of the store and compares it field by field.
// ----------------------------------------------------------------------------
module stack_result_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [swpi_pkg::POS_W-1:0]     position,
  input  swpi_pkg::word_t                value,
  input  logic                           done,
  input  logic [1:0]                     status,
  input  swpi_pkg::word_t                popped_value,
  input  logic [swpi_pkg::CNT_OUT_W-1:0] entry_count,
  output int                             fail_count,
  output int                             replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]                     status;
    swpi_pkg::word_t                popped;
    logic [swpi_pkg::CNT_OUT_W-1:0] level;
  } stack_reply_t;

  swpi_pkg::word_t shadow_words [swpi_pkg::DEPTH];
  int              shadow_level;
  stack_reply_t    replies_due [$];

  // Shadow stack update for one request; returns the reply it should give.
  function automatic stack_reply_t apply_request(input logic [1:0] op,
                                                 input logic [swpi_pkg::POS_W-1:0] pos,
                                                 input swpi_pkg::word_t word);
    stack_reply_t reply;
    int           slot;
    reply.status = swpi_pkg::ST_OK;
    reply.popped = '0;
    case (op)
      swpi_pkg::MODE_PUSH: begin
        if (shadow_level >= swpi_pkg::DEPTH) begin
          reply.status = swpi_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_level] = word;
          shadow_level++;
        end
      end
      swpi_pkg::MODE_POP: begin
        if (shadow_level == 0) begin
          reply.status = swpi_pkg::ST_EMPTY;
          reply.popped = -1;
        end else begin
          shadow_level--;
          reply.popped = shadow_words[shadow_level];
        end
      end
      swpi_pkg::MODE_INSERT: begin
        // position check takes priority over the full check
        if (pos < 1 || int'(pos) > shadow_level + 1) begin
          reply.status = swpi_pkg::ST_BADPOS;
        end else if (shadow_level >= swpi_pkg::DEPTH) begin
          reply.status = swpi_pkg::ST_FULL;
        end else begin
          slot = shadow_level + 1 - int'(pos);
          for (int i = shadow_level; i > slot; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[slot] = word;
          shadow_level++;
        end
      end
      default: ;
    endcase
    reply.level = swpi_pkg::CNT_OUT_W'(shadow_level);
    return reply;
  endfunction

  assign replies_owed = replies_due.size();

  initial begin
    fail_count   = 0;
    shadow_level = 0;
  end

  always @(posedge clk) begin
    stack_reply_t want;
    if (rst) begin
      shadow_level = 0;
      replies_due.delete();
    end else begin
      // result side first: a reply never belongs to a request taken this edge
      if (done) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status=%0d popped=%0d count=%0d",
                   $time, status, popped_value, entry_count);
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (popped_value !== want.popped) begin
            fail_count++;
            $display("%0t: popped_value expected %0d actual %0d",
                     $time, want.popped, popped_value);
          end
          if (entry_count !== want.level) begin
            fail_count++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.level, entry_count);
          end
        end
      end
      if (start && !busy) replies_due.push_back(apply_request(mode, position, value));
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Top level for the stack with positional insert: drives a directed then a
// random stream of push, pop and insert transactions with random idle gaps,
// and leaves prediction and comparison to stack_result_check.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // the spare request code; the block must treat it as a no-op
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         RAND_TXNS  = 800;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [1:0]                     mode;
  logic [swpi_pkg::POS_W-1:0]     position;
  swpi_pkg::word_t                value;
  logic                           done;
  logic [1:0]                     status;
  swpi_pkg::word_t                popped_value;
  logic [swpi_pkg::CNT_OUT_W-1:0] entry_count;
  int                             fail_count;
  int                             replies_owed;

  // random idling switched on and off in stretches
  bit                             gaps_on;

  always #10 clk = ~clk;

  stack_with_positional_insert_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .position     (position),
    .value        (value),
    .done         (done),
    .status       (status),
    .popped_value (popped_value),
    .entry_count  (entry_count)
  );

  stack_result_check result_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .position     (position),
    .value        (value),
    .done         (done),
    .status       (status),
    .popped_value (popped_value),
    .entry_count  (entry_count),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  // Idle length after a transaction: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Present one transaction and hold it until the block takes it. start only
  // drops when a gap follows, so it never gets two updates in one step.
  task automatic issue(input logic [1:0] op, input logic [swpi_pkg::POS_W-1:0] pos,
                       input swpi_pkg::word_t word);
    int gap;
    start    <= 1'b1;
    mode     <= op;
    position <= pos;
    value    <= word;
    do @(posedge clk); while (busy);
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      mode  <= 2'($urandom);
      value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Word mix: mostly full-range, some extremes, some small signed values.
  function automatic swpi_pkg::word_t pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return '0;
        default: return -1;
      endcase
    end
    return $signed($urandom_range(0, 20)) - 10;
  endfunction

  // Stop the run if it hangs
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                         r;
    int                         push_w;
    int                         pop_w;
    logic [1:0]                 op;
    logic [swpi_pkg::POS_W-1:0] pos;

    rst      <= 1'b1;
    start    <= 1'b0;
    mode     <= swpi_pkg::MODE_PUSH;
    position <= '0;
    value    <= '0;
    gaps_on  = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    issue(swpi_pkg::MODE_POP,    8'd0,   32'sd5);          // pop of an empty stack
    issue(swpi_pkg::MODE_INSERT, 8'd1,   32'sh7fffffff);   // insert at top of empty stack
    issue(swpi_pkg::MODE_INSERT, 8'd0,   32'sd1);          // position zero is bad
    issue(swpi_pkg::MODE_INSERT, 8'd3,   32'sd2);          // beyond count+1 is bad
    issue(swpi_pkg::MODE_PUSH,   8'd0,   32'sh80000000);
    issue(swpi_pkg::MODE_PUSH,   8'd255, '0);
    issue(swpi_pkg::MODE_PUSH,   8'd0,   -1);
    issue(swpi_pkg::MODE_INSERT, 8'd5,   32'sh55555555);   // at the bottom (count+1)
    issue(swpi_pkg::MODE_INSERT, 8'd2,   32'sh2aaaaaaa);   // into the middle
    issue(MODE_SPARE,            8'd1,   32'sd77);         // spare code changes nothing
    issue(swpi_pkg::MODE_POP,    8'd0,   '0);
    repeat (11) issue(swpi_pkg::MODE_PUSH, 8'($urandom), $urandom);  // fill to DEPTH
    issue(swpi_pkg::MODE_PUSH,   8'd0,   32'sd9);          // push to a full stack
    issue(swpi_pkg::MODE_INSERT, 8'd1,   32'sd9);          // valid position but full
    issue(swpi_pkg::MODE_INSERT, 8'd17,  32'sd9);          // count+1 on a full stack
    issue(swpi_pkg::MODE_INSERT, 8'd18,  32'sd9);          // bad position wins over full
    issue(swpi_pkg::MODE_INSERT, 8'd255, 32'sd9);
    issue(swpi_pkg::MODE_POP,    8'd0,   '0);

    // ---- random part ----
    // Epochs of 40 transactions lean towards filling, draining or neither,
    // so the stack spends time near empty and near full.
    push_w = 30;
    pop_w  = 30;
    for (int n = 0; n < RAND_TXNS; n++) begin
      if (n % 40 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: begin push_w = 45; pop_w = 15; end
          1: begin push_w = 15; pop_w = 55; end
          default: begin push_w = 30; pop_w = 35; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3)                       op = MODE_SPARE;
      else if (r < 3 + push_w)         op = swpi_pkg::MODE_PUSH;
      else if (r < 3 + push_w + pop_w) op = swpi_pkg::MODE_POP;
      else                             op = swpi_pkg::MODE_INSERT;
      // positions mostly around the live range, sometimes anywhere
      if ($urandom_range(0, 99) < 85) pos = 8'($urandom_range(0, swpi_pkg::DEPTH + 2));
      else                            pos = 8'($urandom_range(0, 255));
      issue(op, pos, pick_word());
    end

    // ---- drain ----
    start <= 1'b0;
    while (replies_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
